FILE: rtl/byte_memory_endian_access_macros.svh
// Assertion macros for the byte memory top level
`ifndef BYTE_MEMORY_ENDIAN_ACCESS_MACROS_SVH
`define BYTE_MEMORY_ENDIAN_ACCESS_MACROS_SVH
`ifndef SYNTHESIS
`define BME_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("byte memory check failed");
`define BME_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("byte memory check failed");
`else
`define BME_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BME_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/bme_pkg.sv
// Constants and types of the byte memory
package bme_pkg;
	localparam int MEM_BYTES = 65536;
	localparam int ADDR_W = (MEM_BYTES > 4) ? $clog2(MEM_BYTES) : 2;
	localparam int BANKS = 4;
	localparam int BANK_ROWS = (MEM_BYTES + BANKS - 1) / BANKS;
	localparam int ROW_W = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;

	localparam logic CMD_READ = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	typedef struct packed {
		logic             we;
		logic             re;
		logic [ROW_W-1:0] row;
		logic [7:0]       wdata;
		logic [1:0]       lane;
	} bank_req_t;
endpackage

FILE: rtl/bme_if.sv
// Request, response and configuration channel interfaces
interface bme_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [1:0]  access_size;
	logic [31:0] address;
	logic [31:0] write_data;
	modport source (output valid, command, access_size, address, write_data, input ready);
	modport sink (input valid, command, access_size, address, write_data, output ready);
endinterface

interface bme_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        out_of_range;
	modport source (output valid, read_data, out_of_range, input ready);
	modport sink (input valid, read_data, out_of_range, output ready);
endinterface

interface bme_cfg_if;
	logic valid;
	logic ready;
	logic big_endian;
	modport source (output valid, big_endian, input ready);
	modport sink (input valid, big_endian, output ready);
endinterface

FILE: rtl/bme_bank.sv
// One byte-wide bank of the memory, registered read
module bme_bank (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [bme_pkg::ROW_W-1:0] row,
	input  logic [7:0]               wdata,
	output logic [7:0]               rdata_q
);
	logic [7:0] mem [bme_pkg::BANK_ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[row] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[row];
		end
	end
endmodule

FILE: rtl/bme_steer.sv
// Address rotation: maps one access onto the four byte banks
module bme_steer (
	input  logic               fire,
	input  logic               big_endian,
	input  logic               command,
	input  logic [1:0]         access_size,
	input  logic [31:0]        address,
	input  logic [31:0]        write_data,
	output logic               oor,
	output logic [3:0]         hit,
	output bme_pkg::bank_req_t bank [bme_pkg::BANKS]
);
	logic [2:0] n;
	logic [1:0] a0;
	logic [bme_pkg::ROW_W-1:0] row0;

	always_comb begin
		case (access_size)
			bme_pkg::SIZE_BYTE: n = 3'd1;
			bme_pkg::SIZE_HALF: n = 3'd2;
			default:            n = 3'd4;
		endcase
	end

	assign a0 = address[1:0];
	assign row0 = bme_pkg::ROW_W'(address >> 2);
	assign oor = ({1'b0, address} + 33'(n)) > 33'(bme_pkg::MEM_BYTES);

	always_comb begin
		logic [1:0] off;
		logic [2:0] rev;
		logic       en;
		for (int b = 0; b < bme_pkg::BANKS; b++) begin
			off = 2'(b) - a0;
			rev = n - 3'd1 - {1'b0, off};
			en = !oor && ({1'b0, off} < n);
			bank[b].lane = big_endian ? rev[1:0] : off;
			bank[b].row = row0 + bme_pkg::ROW_W'(2'(b) < a0);
			bank[b].wdata = write_data[8 * bank[b].lane +: 8];
			bank[b].we = fire && en && (command == bme_pkg::CMD_WRITE);
			bank[b].re = fire && en && (command == bme_pkg::CMD_READ);
			hit[b] = en && (command == bme_pkg::CMD_READ);
		end
	end
endmodule

FILE: rtl/byte_memory_endian_access.sv
// Top level: byte-addressed memory with selectable byte order
//
// channel | dir | beat carries
// req     | in  | command, access_size, address, write_data
// rsp     | out | read_data, out_of_range
// cfg     | in  | big_endian
//
// One beat per cycle unless rsp stalls; rsp.valid is registered after stage 1 (v_s1).
// Four byte banks with address rotation take every byte of an access at once.
// A stalled response holds the bank read registers and stage 1; req.ready drops then.
// Reset clears valids and sets little-endian; memory contents stay undefined.
`include "byte_memory_endian_access_macros.svh"
module byte_memory_endian_access (
	input  logic       clk,
	input  logic       arst_n,
	bme_req_if.sink    req,
	bme_rsp_if.source  rsp,
	bme_cfg_if.sink    cfg
);
	logic big_endian_q;
	logic acc;
	logic adv;
	logic oor;
	logic [3:0] hit;
	logic [3:0] bank_we;
	bme_pkg::bank_req_t bank [bme_pkg::BANKS];
	logic [7:0] rdata [bme_pkg::BANKS];

	logic       v_s1;
	logic       oor_s1;
	logic [3:0] hit_s1;
	logic [1:0] lane_s1 [bme_pkg::BANKS];

	logic        out_v_q;
	logic [31:0] read_data_q;
	logic        oor_q;
	logic [31:0] assembled;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
		end else if (cfg.valid) begin
			big_endian_q <= cfg.big_endian;
		end
	end

	assign adv = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign acc = req.valid && req.ready;

	bme_steer u_steer (
		.fire        (acc),
		.big_endian  (big_endian_q),
		.command     (req.command),
		.access_size (req.access_size),
		.address     (req.address),
		.write_data  (req.write_data),
		.oor         (oor),
		.hit         (hit),
		.bank        (bank)
	);

	assign bank_we = {bank[3].we, bank[2].we, bank[1].we, bank[0].we};

	for (genvar b = 0; b < bme_pkg::BANKS; b++) begin : g_bank
		bme_bank u_bank (
			.clk     (clk),
			.we      (bank[b].we),
			.re      (bank[b].re),
			.row     (bank[b].row),
			.wdata   (bank[b].wdata),
			.rdata_q (rdata[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			oor_s1 <= oor;
			hit_s1 <= hit;
			for (int b = 0; b < bme_pkg::BANKS; b++) begin
				lane_s1[b] <= bank[b].lane;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			assembled[8 * l +: 8] = 8'h00;
			for (int b = 0; b < bme_pkg::BANKS; b++) begin
				if (hit_s1[b] && (lane_s1[b] == 2'(l))) begin
					assembled[8 * l +: 8] = assembled[8 * l +: 8] | rdata[b];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q <= assembled;
			oor_q <= oor_s1;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.read_data = read_data_q;
	assign rsp.out_of_range = oor_q;

	`BME_ASSERT_IMP(a_oor_no_write, clk, arst_n, acc && oor, (hit == 4'b0) && (bank_we == 4'b0))
	`BME_ASSERT_IMP(a_oor_zero_data, clk, arst_n, out_v_q && oor_q, read_data_q == 32'h0)
	`BME_ASSERT_IMP(a_stall_cause, clk, arst_n, !req.ready, v_s1 && out_v_q && !rsp.ready)
	`BME_ASSERT_IMP(a_word_all_banks, clk, arst_n, acc && !oor && req.access_size[1], &(bank_we ^ hit))
	`BME_ASSERT_NXT(a_adv_fills_out, clk, arst_n, adv, out_v_q)
endmodule
